[src/tfcp_pkg.sv]
// Shared types, constants and helpers of the timing frame command parser.
// Depends on nothing; the front, queue, back, top and testbench files refer to it by scoped names.
package tfcp_pkg;

	// Width of the configuration address: three registers at byte addresses 0, 4 and 8.
	localparam int unsigned APB_ADDR_W = 4;

	// Width of a train number carried through the queue; it covers up to 16 trains.
	localparam int unsigned TRAIN_FIELD_W = 4;

	// Depth of the queue between the parser and the executor.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = 2;

	// Saturation limit of the error counters.
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// Register indexes of the configuration port.
	typedef enum logic [1:0] {
		REG_TABLE_CODE  = 2'd0,
		REG_SHOT_CODE   = 2'd1,
		REG_FIRST_IDENT = 2'd2
	} reg_index_t;

	// Event codes reported with every result word.
	typedef enum logic [2:0] {
		EV_TRAIN     = 3'd0,
		EV_SHOT      = 3'd1,
		EV_BAD_CMD   = 3'd2,
		EV_BAD_IDENT = 3'd3,
		EV_BAD_DATA  = 3'd4
	} event_t;

	// Configuration seen by the parser.
	typedef struct packed {
		logic [3:0] table_code;
		logic [3:0] shot_code;
		logic [3:0] first_ident;
	} cfg_t;

	// One operation handed from the parser to the executor.
	typedef struct packed {
		logic                     emit;   // a result word is produced
		event_t                   ev;     // which event, when emit is set
		logic                     store;  // write data into the train table
		logic [TRAIN_FIELD_W-1:0] train;  // train concerned
		logic [1:0]               slot;   // word within the train's row
		logic [31:0]              data;   // table word or shot word
		logic                     last;   // end of buffer: clear per-buffer counts
	} op_t;

	// Payload of one result word.
	typedef struct packed {
		event_t      event_res;
		logic [1:0]  train_index;
		logic [31:0] train_start;
		logic [31:0] train_duration;
		logic [31:0] train_increment;
		logic [31:0] train_bunches;
		logic [31:0] shot_number;
		logic [15:0] bad_command_count;
		logic [15:0] bad_ident_count;
		logic [15:0] bad_data_count;
	} result_t;

	// Saturating increment of an error counter.
	function automatic logic [15:0] sat_inc(input logic [15:0] count);
		sat_inc = (count == COUNT_MAX) ? count : count + 16'd1;
	endfunction

endpackage

[src/tfcp_if.sv]
// Valid/ready channel interfaces for frame words in and result words out.
// Depends on nothing.
interface tfcp_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] frame_word;
	logic        last_frame;

	modport source(output valid, output frame_word, output last_frame, input ready);
	modport sink(input valid, input frame_word, input last_frame, output ready);
endinterface

interface tfcp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [1:0]  train_index;
	logic [31:0] train_start;
	logic [31:0] train_duration;
	logic [31:0] train_increment;
	logic [31:0] train_bunches;
	logic [31:0] shot_number;
	logic [15:0] bad_command_count;
	logic [15:0] bad_ident_count;
	logic [15:0] bad_data_count;

	modport source(output valid, output event_res, output train_index, output train_start,
		output train_duration, output train_increment, output train_bunches,
		output shot_number, output bad_command_count, output bad_ident_count,
		output bad_data_count, input ready);
	modport sink(input valid, input event_res, input train_index, input train_start,
		input train_duration, input train_increment, input train_bunches,
		input shot_number, input bad_command_count, input bad_ident_count,
		input bad_data_count, output ready);
endinterface

[src/tfcp_front.sv]
// Front parser: accepts frame words, tracks the parse mode and gathers table bytes.
// Depends on tfcp_pkg and tfcp_in_if; emits operations towards the queue.
module tfcp_front #(
	parameter int unsigned TRAIN_COUNT = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tfcp_pkg::cfg_t    cfg,
	tfcp_in_if.sink           frame_in,
	output logic              push_valid,
	output tfcp_pkg::op_t     push_op,
	input  logic              push_ready
);

	localparam int unsigned TRAIN_W = (TRAIN_COUNT > 1) ? $clog2(TRAIN_COUNT) : 1;

	typedef enum logic [3:0] {
		MODE_IDLE    = 4'b0001,
		MODE_SECTION = 4'b0010,
		MODE_DATA    = 4'b0100,
		MODE_SHOT    = 4'b1000
	} parse_mode_t;

	parse_mode_t        mode_q, mode_d;
	logic               follows_q, follows_d;
	logic [TRAIN_W-1:0] train_q, train_d;
	logic [3:0]         pos_q, pos_d;
	logic [31:0]        acc_q, acc_d;

	logic        accept;
	logic        is_cmd;
	logic [3:0]  code;
	logic [3:0]  ident;
	logic [3:0]  offset;
	logic        known_train;
	logic [31:0] acc_merged;
	logic        gen;
	tfcp_pkg::op_t op;

	assign frame_in.ready = push_ready;
	assign accept = frame_in.valid && push_ready;

	// Classification of the incoming word.
	assign is_cmd      = |frame_in.frame_word[15:8];
	assign code        = frame_in.frame_word[7:4];
	assign ident       = frame_in.frame_word[3:0];
	assign offset      = ident - cfg.first_ident;
	assign known_train = (ident >= cfg.first_ident) && ({1'b0, offset} < 5'(TRAIN_COUNT));
	assign acc_merged  = acc_q | ({24'b0, frame_in.frame_word[7:0]} << {pos_q[1:0], 3'b000});

	// Next parse state and the operation that the word causes.
	always_comb begin
		mode_d    = mode_q;
		follows_d = follows_q;
		train_d   = train_q;
		pos_d     = pos_q;
		acc_d     = acc_q;
		op        = '0;
		op.ev     = tfcp_pkg::EV_TRAIN;
		op.train  = tfcp_pkg::TRAIN_FIELD_W'(train_q);
		op.slot   = pos_q[3:2];
		op.data   = acc_merged;
		case (mode_q)
			MODE_IDLE: begin
				if (is_cmd) begin
					if (code == cfg.table_code) begin
						mode_d = MODE_SECTION;
						if (known_train) begin
							train_d   = TRAIN_W'(offset);
							follows_d = 1'b1;
						end else begin
							follows_d = 1'b0;
							op.emit   = 1'b1;
							op.ev     = tfcp_pkg::EV_BAD_IDENT;
						end
					end else if (code == cfg.shot_code) begin
						mode_d = MODE_SHOT;
					end else begin
						op.emit = 1'b1;
						op.ev   = tfcp_pkg::EV_BAD_CMD;
					end
				end
			end
			MODE_SECTION: begin
				// The section word is skipped whatever it holds.
				if (follows_q) begin
					mode_d = MODE_DATA;
					pos_d  = 4'd0;
					acc_d  = 32'd0;
				end else begin
					mode_d = MODE_IDLE;
				end
				follows_d = 1'b0;
			end
			MODE_DATA: begin
				if (is_cmd) begin
					// Interrupted table: completed words stay, the partial one is dropped.
					op.emit = 1'b1;
					op.ev   = tfcp_pkg::EV_BAD_DATA;
					mode_d  = MODE_IDLE;
				end else begin
					acc_d = acc_merged;
					if (pos_q[1:0] == 2'd3) begin
						op.store = 1'b1;
						acc_d    = 32'd0;
					end
					if (pos_q == 4'd15) begin
						op.emit = 1'b1;
						op.ev   = tfcp_pkg::EV_TRAIN;
						pos_d   = 4'd0;
						mode_d  = MODE_IDLE;
					end else begin
						pos_d = pos_q + 4'd1;
					end
				end
			end
			MODE_SHOT: begin
				op.emit = 1'b1;
				op.ev   = tfcp_pkg::EV_SHOT;
				op.data = frame_in.frame_word;
				mode_d  = MODE_IDLE;
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase
		op.last = frame_in.last_frame;
		// End of buffer abandons any pending read.
		if (frame_in.last_frame) begin
			mode_d    = MODE_IDLE;
			follows_d = 1'b0;
			pos_d     = 4'd0;
			acc_d     = 32'd0;
		end
	end

	assign gen        = op.emit || op.store || op.last;
	assign push_valid = frame_in.valid && gen;
	assign push_op    = op;

	// Parse state registers, updated on each accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			follows_q <= 1'b0;
			train_q   <= '0;
			pos_q     <= 4'd0;
			acc_q     <= 32'd0;
		end else if (accept) begin
			mode_q    <= mode_d;
			follows_q <= follows_d;
			train_q   <= train_d;
			pos_q     <= pos_d;
			acc_q     <= acc_d;
		end
	end

endmodule

[src/tfcp_queue.sv]
// Short operation queue between the parser and the executor.
// Depends on tfcp_pkg for the operation type and the queue depth.
module tfcp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  tfcp_pkg::op_t push_op,
	output logic          push_ready,
	output logic          pop_valid,
	output tfcp_pkg::op_t pop_op,
	input  logic          pop_ready
);

	localparam int unsigned CNT_W = tfcp_pkg::QUEUE_PTR_W + 1;

	tfcp_pkg::op_t                    entry_q [tfcp_pkg::QUEUE_DEPTH];
	logic [tfcp_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [tfcp_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0]                 count_q;
	logic                             push;
	logic                             pop;

	assign push_ready = (count_q != CNT_W'(tfcp_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_op     = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/tfcp_back.sv]
// Executor: applies queued operations to the train table, shot store and counters.
// Depends on tfcp_pkg and tfcp_out_if; drives the result word register.
module tfcp_back #(
	parameter int unsigned TRAIN_COUNT = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	input  tfcp_pkg::op_t pop_op,
	output logic          pop_ready,
	tfcp_out_if.source    result_out
);

	localparam int unsigned TRAIN_W = (TRAIN_COUNT > 1) ? $clog2(TRAIN_COUNT) : 1;

	logic [3:0][31:0]   row_q [TRAIN_COUNT];
	logic [31:0]        shot_q;
	logic [15:0]        cmd_cnt_q;
	logic [15:0]        ident_cnt_q;
	logic [15:0]        data_cnt_q;
	logic               out_valid_q;
	tfcp_pkg::result_t  res_q;

	logic [TRAIN_W-1:0] idx;
	logic [3:0][31:0]   row_new;
	logic [31:0]        shot_d;
	logic [15:0]        cmd_cnt_d;
	logic [15:0]        ident_cnt_d;
	logic [15:0]        data_cnt_d;
	logic               with_train;
	logic               pop;
	tfcp_pkg::result_t  res_d;

	// An operation that yields a word waits for the output register to free up.
	assign pop_ready = !pop_op.emit || !out_valid_q || result_out.ready;
	assign pop       = pop_valid && pop_ready;

	// Effect of the operation at the head of the queue.
	always_comb begin
		idx     = pop_op.train[TRAIN_W-1:0];
		row_new = row_q[idx];
		if (pop_op.store) begin
			row_new[pop_op.slot] = pop_op.data;
		end
		shot_d      = (pop_op.emit && pop_op.ev == tfcp_pkg::EV_SHOT) ? pop_op.data : shot_q;
		cmd_cnt_d   = (pop_op.emit && pop_op.ev == tfcp_pkg::EV_BAD_CMD) ?
			tfcp_pkg::sat_inc(cmd_cnt_q) : cmd_cnt_q;
		ident_cnt_d = (pop_op.emit && pop_op.ev == tfcp_pkg::EV_BAD_IDENT) ?
			tfcp_pkg::sat_inc(ident_cnt_q) : ident_cnt_q;
		data_cnt_d  = (pop_op.emit && pop_op.ev == tfcp_pkg::EV_BAD_DATA) ?
			tfcp_pkg::sat_inc(data_cnt_q) : data_cnt_q;
		with_train  = (pop_op.ev == tfcp_pkg::EV_TRAIN) || (pop_op.ev == tfcp_pkg::EV_BAD_DATA);

		res_d                   = '0;
		res_d.event_res         = pop_op.ev;
		res_d.shot_number       = shot_d;
		res_d.bad_command_count = cmd_cnt_d;
		res_d.bad_ident_count   = ident_cnt_d;
		res_d.bad_data_count    = data_cnt_d;
		if (with_train) begin
			res_d.train_index     = 2'(idx);
			res_d.train_start     = row_new[0];
			res_d.train_duration  = row_new[1];
			res_d.train_increment = row_new[2];
			res_d.train_bunches   = row_new[3];
		end
	end

	// Train table, shot store and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int unsigned i = 0; i < TRAIN_COUNT; i++) begin
				row_q[i] <= '0;
			end
			shot_q      <= 32'd0;
			cmd_cnt_q   <= 16'd0;
			ident_cnt_q <= 16'd0;
			data_cnt_q  <= 16'd0;
		end else if (pop) begin
			if (pop_op.store) begin
				row_q[idx] <= row_new;
			end
			shot_q      <= shot_d;
			data_cnt_q  <= data_cnt_d;
			// Per-buffer counts clear after the final word of a buffer.
			cmd_cnt_q   <= pop_op.last ? 16'd0 : cmd_cnt_d;
			ident_cnt_q <= pop_op.last ? 16'd0 : ident_cnt_d;
		end
	end

	// Output register handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && pop_op.emit) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (pop && pop_op.emit) begin
			res_q <= res_d;
		end
	end

	assign result_out.valid             = out_valid_q;
	assign result_out.event_res         = res_q.event_res;
	assign result_out.train_index       = res_q.train_index;
	assign result_out.train_start       = res_q.train_start;
	assign result_out.train_duration    = res_q.train_duration;
	assign result_out.train_increment   = res_q.train_increment;
	assign result_out.train_bunches     = res_q.train_bunches;
	assign result_out.shot_number       = res_q.shot_number;
	assign result_out.bad_command_count = res_q.bad_command_count;
	assign result_out.bad_ident_count   = res_q.bad_ident_count;
	assign result_out.bad_data_count    = res_q.bad_data_count;

endmodule

[src/timing_frame_command_parser.sv]
// Top level of the timing frame command parser: configuration registers and wiring.
// Depends on tfcp_pkg, tfcp_if, tfcp_front, tfcp_queue and tfcp_back.

// The block takes one frame word per clock cycle on frame_in while the queue has
// room. The front parser classifies each word in the cycle it is accepted and pushes
// an operation into a four-entry queue; the executor behind it updates the train
// table, shot store and error counters and loads the result register from the queue
// head. Input is refused only while the queue is full, which happens when result
// words are not taken. Table, shot and counter state clears at reset; the three
// command registers are written over the APB port at byte addresses 0, 4 and 8 and
// take effect on the next accepted word.
module timing_frame_command_parser #(
	parameter int unsigned TRAIN_COUNT = 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	tfcp_in_if.sink                           frame_in,
	tfcp_out_if.source                        event_out,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tfcp_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	tfcp_pkg::cfg_t cfg_q;
	logic           cfg_write;
	logic [1:0]     reg_sel;

	logic           push_valid;
	logic           push_ready;
	tfcp_pkg::op_t  push_op;
	logic           pop_valid;
	logic           pop_ready;
	tfcp_pkg::op_t  pop_op;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign reg_sel   = paddr[3:2];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.table_code  <= 4'd1;
			cfg_q.shot_code   <= 4'd2;
			cfg_q.first_ident <= 4'd1;
		end else if (cfg_write) begin
			case (reg_sel)
				tfcp_pkg::REG_TABLE_CODE:  cfg_q.table_code  <= pwdata[3:0];
				tfcp_pkg::REG_SHOT_CODE:   cfg_q.shot_code   <= pwdata[3:0];
				tfcp_pkg::REG_FIRST_IDENT: cfg_q.first_ident <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_sel)
			tfcp_pkg::REG_TABLE_CODE:  prdata = {28'd0, cfg_q.table_code};
			tfcp_pkg::REG_SHOT_CODE:   prdata = {28'd0, cfg_q.shot_code};
			tfcp_pkg::REG_FIRST_IDENT: prdata = {28'd0, cfg_q.first_ident};
			default:                   prdata = 32'd0;
		endcase
	end

	tfcp_front #(
		.TRAIN_COUNT(TRAIN_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.frame_in   (frame_in),
		.push_valid (push_valid),
		.push_op    (push_op),
		.push_ready (push_ready)
	);

	tfcp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_op    (push_op),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_op     (pop_op),
		.pop_ready  (pop_ready)
	);

	tfcp_back #(
		.TRAIN_COUNT(TRAIN_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_op     (pop_op),
		.pop_ready  (pop_ready),
		.result_out (event_out)
	);

endmodule

[tb/timing_frame_command_parser_tb.sv]
// Self-checking testbench of the timing frame command parser: frame words, result words
// and the APB register port. Relies on tfcp_pkg, the channel interfaces in tfcp_if and
// the block itself.
module timing_frame_command_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_TRAINS    = 3;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 2000;
	localparam int COUNT_ROUNDS  = 10;
	localparam int REPORT_LINES  = 50;

	typedef enum logic [1:0] {
		PS_IDLE,
		PS_SECTION,
		PS_DATA,
		PS_SHOT
	} parse_state_t;

	logic                            clk     = 1'b0;
	logic                            arst_n  = 1'b0;
	logic                            psel    = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite  = 1'b0;
	logic [tfcp_pkg::APB_ADDR_W-1:0] paddr   = '0;
	logic [31:0]                     pwdata  = '0;
	logic [31:0]                     prdata;
	logic                            pready;

	tfcp_in_if  frame_in();
	tfcp_out_if event_out();

	timing_frame_command_parser #(
		.TRAIN_COUNT(NUM_TRAINS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame_in (frame_in),
		.event_out(event_out),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// Mirror of the command registers.
	logic [3:0] cfg_table = 4'd1;
	logic [3:0] cfg_shot  = 4'd2;
	logic [3:0] cfg_first = 4'd1;

	// Mirror of the parser and its stores.
	parse_state_t parse_state   = PS_IDLE;
	bit           table_follows = 1'b0;
	logic [1:0]   cur_train     = '0;
	logic [3:0]   byte_idx      = '0;
	logic [31:0]  assembly      = '0;
	logic [31:0]  train_words [NUM_TRAINS*4] = '{default: '0};
	logic [31:0]  last_shot     = '0;
	logic [15:0]  cnt_cmd       = '0;
	logic [15:0]  cnt_ident     = '0;
	logic [15:0]  cnt_data      = '0;

	tfcp_pkg::result_t expected_events [$];

	// Run bookkeeping.
	bit           in_idling      = 1'b0;
	bit           out_idling     = 1'b0;
	int unsigned  stall_left     = 0;
	int unsigned  quiet_cycles   = 0;
	int unsigned  mismatch_count = 0;
	int unsigned  results_checked = 0;
	int unsigned  words_sent     = 0;
	int unsigned  words_parsed   = 0;
	int unsigned  settings_used  = 0;
	int unsigned  event_tally [5] = '{default: 0};

	task automatic report_mismatch(input string msg);
		if (mismatch_count < REPORT_LINES)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	function automatic logic [15:0] bumped(input logic [15:0] count);
		return (count == 16'hFFFF) ? count : count + 16'd1;
	endfunction

	// Queue the result word that the current state reports.
	task automatic post_event(input tfcp_pkg::event_t ev, input bit with_train);
		tfcp_pkg::result_t r;
		r = '0;
		r.event_res = ev;
		if (with_train) begin
			r.train_index     = cur_train;
			r.train_start     = train_words[cur_train*4];
			r.train_duration  = train_words[cur_train*4 + 1];
			r.train_increment = train_words[cur_train*4 + 2];
			r.train_bunches   = train_words[cur_train*4 + 3];
		end
		r.shot_number       = last_shot;
		r.bad_command_count = cnt_cmd;
		r.bad_ident_count   = cnt_ident;
		r.bad_data_count    = cnt_data;
		expected_events.push_back(r);
	endtask

	// Advance the parser mirror by one accepted frame word.
	task automatic parse_word(input logic [31:0] w, input logic last, output bit ignored);
		bit         is_cmd;
		logic [3:0] code;
		logic [3:0] ident;
		logic [3:0] offset;
		is_cmd  = (w[15:8] != 8'h00);
		ignored = 1'b0;
		code    = w[7:4];
		ident   = w[3:0];
		offset  = ident - cfg_first;
		case (parse_state)
			PS_IDLE: begin
				if (!is_cmd) begin
					ignored = !last;
				end else if (code == cfg_table) begin
					parse_state = PS_SECTION;
					if (ident >= cfg_first && offset < NUM_TRAINS) begin
						cur_train     = offset[1:0];
						table_follows = 1'b1;
					end else begin
						table_follows = 1'b0;
						cnt_ident     = bumped(cnt_ident);
						post_event(tfcp_pkg::EV_BAD_IDENT, 1'b0);
					end
				end else if (code == cfg_shot) begin
					parse_state = PS_SHOT;
				end else begin
					cnt_cmd = bumped(cnt_cmd);
					post_event(tfcp_pkg::EV_BAD_CMD, 1'b0);
				end
			end
			PS_SECTION: begin
				// The section word is dropped whatever it holds.
				if (table_follows) begin
					parse_state = PS_DATA;
					byte_idx    = '0;
					assembly    = '0;
				end else begin
					parse_state = PS_IDLE;
				end
				table_follows = 1'b0;
			end
			PS_DATA: begin
				if (is_cmd) begin
					cnt_data = bumped(cnt_data);
					post_event(tfcp_pkg::EV_BAD_DATA, 1'b1);
					parse_state = PS_IDLE;
				end else begin
					assembly = assembly | (32'(w[7:0]) << (8 * byte_idx[1:0]));
					if (byte_idx[1:0] == 2'd3) begin
						train_words[cur_train*4 + byte_idx[3:2]] = assembly;
						assembly = '0;
					end
					if (byte_idx == 4'd15) begin
						byte_idx    = '0;
						parse_state = PS_IDLE;
						post_event(tfcp_pkg::EV_TRAIN, 1'b1);
					end else begin
						byte_idx = byte_idx + 4'd1;
					end
				end
			end
			default: begin
				last_shot   = w;
				parse_state = PS_IDLE;
				post_event(tfcp_pkg::EV_SHOT, 1'b0);
			end
		endcase
		// The end of a buffer abandons any pending read and clears the per-buffer counts.
		if (last) begin
			cnt_cmd       = '0;
			cnt_ident     = '0;
			parse_state   = PS_IDLE;
			table_follows = 1'b0;
			byte_idx      = '0;
			assembly      = '0;
		end
	endtask

	function automatic int unsigned gap_length();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return $urandom_range(1, 3);
		if (pick < 95)
			return $urandom_range(4, 8);
		return $urandom_range(20, 40);
	endfunction

	// Offer one frame word, wait for it to be taken and predict its effect.
	task automatic send_word(input logic [31:0] w, input logic last);
		int unsigned gap;
		bit          ignored;
		gap = (in_idling && $urandom_range(0, 99) < 30) ? gap_length() : 0;
		if (gap != 0) begin
			frame_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_in.valid      <= 1'b1;
		frame_in.frame_word <= w;
		frame_in.last_frame <= last;
		do @(posedge clk); while (!frame_in.ready);
		parse_word(w, last, ignored);
		words_sent++;
		if (!ignored)
			words_parsed++;
	endtask

	// Hold the input until every expected word has come and the pipeline is empty.
	task automatic wait_for_quiet();
		frame_in.valid <= 1'b0;
		do @(posedge clk); while (expected_events.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_transfer(input tfcp_pkg::reg_index_t idx, input bit write,
		input logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
	endtask

	// Write all three command registers while the block is idle and read them back.
	task automatic set_codes(input logic [3:0] table_code, input logic [3:0] shot_code,
		input logic [3:0] first_ident);
		logic [31:0] readback;
		wait_for_quiet();
		apb_transfer(tfcp_pkg::REG_TABLE_CODE, 1'b1, {28'($urandom()), table_code},
			readback);
		apb_transfer(tfcp_pkg::REG_SHOT_CODE, 1'b1, {28'($urandom()), shot_code},
			readback);
		apb_transfer(tfcp_pkg::REG_FIRST_IDENT, 1'b1, {28'($urandom()), first_ident},
			readback);
		cfg_table = table_code;
		cfg_shot  = shot_code;
		cfg_first = first_ident;
		apb_transfer(tfcp_pkg::REG_TABLE_CODE, 1'b0, '0, readback);
		check_field("table code readback", readback[3:0], table_code);
		apb_transfer(tfcp_pkg::REG_SHOT_CODE, 1'b0, '0, readback);
		check_field("shot code readback", readback[3:0], shot_code);
		apb_transfer(tfcp_pkg::REG_FIRST_IDENT, 1'b0, '0, readback);
		check_field("first ident readback", readback[3:0], first_ident);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [31:0] command_word(input logic [3:0] code, input logic [3:0] ident);
		logic [31:0] w;
		w       = $urandom();
		w[15:8] = 8'($urandom_range(1, 255));
		w[7:0]  = {code, ident};
		return w;
	endfunction

	function automatic logic [31:0] data_word(input logic [7:0] value);
		logic [31:0] w;
		w       = $urandom();
		w[15:8] = 8'h00;
		w[7:0]  = value;
		return w;
	endfunction

	function automatic logic [7:0] random_byte();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 8'h00;
		if (pick == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// A command code that is neither the table nor the shot code.
	function automatic logic [3:0] foreign_code();
		logic [3:0] code;
		do code = 4'($urandom_range(0, 15));
		while (code == cfg_table || code == cfg_shot);
		return code;
	endfunction

	function automatic logic random_last();
		return ($urandom_range(0, 59) == 0);
	endfunction

	// A table command, its section word and, for a known train, sixteen bytes that are
	// sometimes cut short by a stray command.
	task automatic send_table_sequence();
		logic [3:0]  ident;
		logic [3:0]  offset;
		int unsigned cut;
		if ($urandom_range(0, 6) != 0) begin
			ident = cfg_first + 4'($urandom_range(0, NUM_TRAINS - 1));
		end else begin
			do begin
				ident  = 4'($urandom_range(0, 15));
				offset = ident - cfg_first;
			end while (ident >= cfg_first && offset < NUM_TRAINS);
		end
		offset = ident - cfg_first;
		send_word(command_word(cfg_table, ident), random_last());
		send_word($urandom(), random_last());
		if (ident >= cfg_first && offset < NUM_TRAINS) begin
			cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 16;
			for (int i = 0; i < 16; i++) begin
				if (i == cut) begin
					send_word(command_word(4'($urandom_range(0, 15)),
						4'($urandom_range(0, 15))), random_last());
					break;
				end
				send_word(data_word(random_byte()), random_last());
			end
		end
	endtask

	// Mostly well-formed command sequences with random content, plus noise.
	task automatic random_traffic(input int unsigned target);
		int unsigned goal;
		int unsigned pick;
		goal = words_parsed + target;
		while (words_parsed < goal) begin
			if ($urandom_range(0, 9) == 0)
				in_idling = !in_idling;
			if ($urandom_range(0, 9) == 0)
				out_idling = !out_idling;
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_table_sequence();
			end else if (pick < 60) begin
				send_word(command_word(cfg_shot, 4'($urandom_range(0, 15))), random_last());
				send_word($urandom(), random_last());
			end else if (pick < 72) begin
				send_word(command_word(foreign_code(), 4'($urandom_range(0, 15))),
					random_last());
			end else if (pick < 88) begin
				send_word(data_word(random_byte()), random_last());
			end else begin
				send_word($urandom(), random_last());
			end
		end
	endtask

	// Data while idle, shot capture, unknown codes and unknown train identifiers.
	task automatic test_idle_commands();
		send_word(32'h0000_0000, 1'b0);
		send_word(32'hFFFF_00FF, 1'b0);
		send_word(32'h0000_0120, 1'b0);
		// A shot word is taken whole even when it looks like a command.
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'hFFFF_FF2F, 1'b0);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'hFFFF_FFF0, 1'b0);
		send_word(32'h0000_0100, 1'b0);
		// Identifier below the first train, then one past the last; sections still skipped.
		send_word(32'h0000_0110, 1'b0);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h0000_FF14, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);
	endtask

	// A complete table for the first train behind a section word that is a command.
	task automatic test_table_load();
		logic [7:0] value;
		send_word(32'h0000_8011, 1'b0);
		send_word(32'h0000_FF22, 1'b0);
		for (int i = 0; i < 16; i++) begin
			case (i)
				0:       value = 8'h00;
				1:       value = 8'hFF;
				2:       value = 8'h80;
				3:       value = 8'h01;
				default: value = {4'(i), ~4'(i)};
			endcase
			send_word({(i % 2 == 0) ? 16'hFFFF : 16'h0000, 8'h00, value}, 1'b0);
		end
	endtask

	// A table broken by a command, then buffer ends that abandon reads and clear counts.
	task automatic test_broken_table();
		send_word(32'h0000_0113, 1'b0);
		send_word(32'h1234_5678, 1'b0);
		send_word(32'h0000_00A5, 1'b0);
		send_word(32'h0000_005A, 1'b0);
		send_word(32'h0000_00C3, 1'b0);
		send_word(32'h0000_003C, 1'b0);
		send_word(32'h0000_0077, 1'b0);
		send_word(32'h0000_FFFF, 1'b0);
		send_word(32'h0000_0120, 1'b1);
		send_word(32'h0000_0055, 1'b0);
		send_word(32'h0000_0130, 1'b1);
		send_word(32'h0000_0130, 1'b0);
	endtask

	task automatic test_random_default();
		in_idling  = 1'b1;
		out_idling = 1'b1;
		random_traffic(100);
	endtask

	// Extreme code settings, equal codes, then back to the reset values.
	task automatic test_code_settings();
		set_codes(4'd0, 4'd15, 4'd13);
		random_traffic(80);
		set_codes(4'd15, 4'd0, 4'd0);
		random_traffic(80);
		set_codes(4'd7, 4'd7, 4'd5);
		random_traffic(80);
		set_codes(4'd1, 4'd2, 4'd1);
		random_traffic(40);
	endtask

	// Raise all three error counters many times within one buffer, then end the buffer.
	task automatic test_error_counts();
		logic [31:0] bad_ident_cmd;
		logic [31:0] table_cmd;
		logic [31:0] stray_cmd;
		wait_for_quiet();
		in_idling     = 1'b0;
		out_idling    = 1'b0;
		bad_ident_cmd = command_word(cfg_table, cfg_first - 4'd1);
		table_cmd     = command_word(cfg_table, cfg_first);
		stray_cmd     = command_word(foreign_code(), 4'd0);
		repeat (COUNT_ROUNDS) begin
			send_word(bad_ident_cmd, 1'b0);
			send_word(32'h0000_0000, 1'b0);
			send_word(table_cmd, 1'b0);
			send_word(32'h0000_0000, 1'b0);
			send_word(stray_cmd, 1'b0);
			send_word(stray_cmd, 1'b0);
		end
		send_word(stray_cmd, 1'b1);
		send_word(stray_cmd, 1'b0);
	endtask

	// Compare each result word with the oldest expectation.
	task automatic check_result();
		tfcp_pkg::result_t want;
		if (event_out.event_res < 5)
			event_tally[event_out.event_res]++;
		if (expected_events.size() == 0) begin
			report_mismatch($sformatf("result word with event %0d arrived unexpected",
				event_out.event_res));
			return;
		end
		want = expected_events.pop_front();
		results_checked++;
		check_field("event_res", event_out.event_res, want.event_res);
		check_field("train_index", event_out.train_index, want.train_index);
		check_field("train_start", event_out.train_start, want.train_start);
		check_field("train_duration", event_out.train_duration, want.train_duration);
		check_field("train_increment", event_out.train_increment, want.train_increment);
		check_field("train_bunches", event_out.train_bunches, want.train_bunches);
		check_field("shot_number", event_out.shot_number, want.shot_number);
		check_field("bad_command_count", event_out.bad_command_count,
			want.bad_command_count);
		check_field("bad_ident_count", event_out.bad_ident_count, want.bad_ident_count);
		check_field("bad_data_count", event_out.bad_data_count, want.bad_data_count);
	endtask

	// Result side: check taken words and stall the receiver at random.
	always @(posedge clk) begin
		if (arst_n && event_out.valid && event_out.ready)
			check_result();
		if (stall_left != 0) begin
			stall_left--;
			event_out.ready <= 1'b0;
		end else if (out_idling && $urandom_range(0, 99) < 25) begin
			stall_left = gap_length() - 1;
			event_out.ready <= 1'b0;
		end else begin
			event_out.ready <= 1'b1;
		end
	end

	// Watchdog: end the run when no word moves for too long.
	initial begin
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((frame_in.valid && frame_in.ready) || (event_out.valid && event_out.ready)
				|| psel)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// Test sequence.
	initial begin
		frame_in.valid      <= 1'b0;
		frame_in.frame_word <= '0;
		frame_in.last_frame <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_commands();
		test_table_load();
		test_broken_table();
		test_random_default();
		test_code_settings();
		test_error_counts();
		wait_for_quiet();
		$display("Sent %0d frame words (%0d parsed), %0d code settings, %0d results checked.",
			words_sent, words_parsed, settings_used, results_checked);
		$display("Events: %0d train, %0d shot, %0d bad cmd, %0d bad ident, %0d bad data.",
			event_tally[0], event_tally[1], event_tally[2], event_tally[3], event_tally[4]);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[timing_frame_command_parser.f]
src/tfcp_pkg.sv
src/tfcp_if.sv
src/tfcp_front.sv
src/tfcp_queue.sv
src/tfcp_back.sv
src/timing_frame_command_parser.sv
tb/timing_frame_command_parser_tb.sv
